// File: rtl/rpts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpts_pkg
// Shared constants and controller/datapath interface types for the ring pair
// triangle stitcher.
// ----------------------------------------------------------------------------
package rpts_pkg;

  localparam int MAX_SEGMENTS_DEF = 32;
  localparam int INDEX_BITS_DEF   = 16;

  localparam int SEG_W      = 6;   // ring_segments field
  localparam int VTX_W      = 16;  // vertex index fields
  localparam int IN_DATA_W  = 8;   // ring_segments padded to a byte
  localparam int OUT_DATA_W = 3 * VTX_W;

  // controller -> datapath
  typedef struct packed {
    logic load_first;  // start a new mesh with this ring
    logic start;       // latch a ring pair and prime the stitch counters
    logic emit;        // produce one triangle into the output register
  } rpts_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic new_mesh;    // incoming ring begins a mesh
    logic pair_empty;  // incoming pair yields no triangles
    logic last_step;   // current triangle is the last of the pair
  } rpts_sts_t;

endpackage
`default_nettype wire

// File: rtl/ring_pair_triangle_stitcher.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ring_pair_triangle_stitcher
// Stitches consecutive rings of a tube mesh into index triangles.
// ----------------------------------------------------------------------------
// Each input word is one ring (segment count, first-ring flag in tuser). The
// first ring of a mesh only records its segment count and sets the base
// vertex to zero; every later ring is stitched to the one before it and
// yields numA+numB triangles, streamed one per cycle by the stitch counter
// while the output is not stalled, the last one flagged with tlast. A new
// ring is not taken until the last triangle of the pair has been emitted.
// tuser on the output flags a vertex index that wrapped past INDEX_BITS
// bits, sticky from the ring where the base wrapped until the next first
// ring. The final triangle may wait in the output register while the next
// ring is taken.
// ----------------------------------------------------------------------------
module ring_pair_triangle_stitcher #(
  parameter int MAX_SEGMENTS = rpts_pkg::MAX_SEGMENTS_DEF,
  parameter int INDEX_BITS   = rpts_pkg::INDEX_BITS_DEF
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_tvalid,
  output logic                               in_tready,
  input  wire  [rpts_pkg::IN_DATA_W-1:0]     in_tdata,   // [5:0] ring_segments
  input  wire                                in_tuser,   // first_ring
  output logic                               out_tvalid,
  input  wire                                out_tready,
  output logic [rpts_pkg::OUT_DATA_W-1:0]    out_tdata,  // vertex_a, vertex_b, vertex_c
  output logic                               out_tlast,  // last_triangle
  output logic                               out_tuser   // index_overflow
);
  import rpts_pkg::*;

  rpts_cmd_t        cmd;
  rpts_sts_t        sts;
  logic [VTX_W-1:0] vertex_a, vertex_b, vertex_c;

  rpts_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  rpts_dp #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .INDEX_BITS   (INDEX_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .ring_segments  (in_tdata[SEG_W-1:0]),
    .first_ring     (in_tuser),
    .cmd            (cmd),
    .sts            (sts),
    .vertex_a       (vertex_a),
    .vertex_b       (vertex_b),
    .vertex_c       (vertex_c),
    .last_triangle  (out_tlast),
    .index_overflow (out_tuser)
  );

  assign out_tdata = {vertex_c, vertex_b, vertex_a};

endmodule
`default_nettype wire

// File: rtl/rpts_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpts_ctrl
// Sequencer: accepts rings, walks the stitch loop one triangle per cycle
// while the output slot is free, and owns the output valid flag.
// ----------------------------------------------------------------------------
module rpts_ctrl (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_tvalid,
  output logic                 in_tready,
  output logic                 out_tvalid,
  input  wire                  out_tready,
  input  rpts_pkg::rpts_sts_t  sts,
  output rpts_pkg::rpts_cmd_t  cmd
);
  import rpts_pkg::*;

  localparam logic [0:0] ST_IDLE = 1'b0;
  localparam logic [0:0] ST_RUN  = 1'b1;

  logic [0:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;
  logic       slot_free;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign accept     = in_tvalid && in_tready;
  assign slot_free  = !out_valid_r || out_tready;

  always_comb begin
    state_nxt      = state_r;
    cmd.load_first = 1'b0;
    cmd.start      = 1'b0;
    cmd.emit       = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (sts.new_mesh) begin
            cmd.load_first = 1'b1;
          end else begin
            cmd.start = 1'b1;
            if (!sts.pair_empty) begin
              state_nxt = ST_RUN;
            end
          end
        end
      end
      ST_RUN: begin
        if (slot_free) begin
          cmd.emit = 1'b1;
          if (sts.last_step) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/rpts_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpts_dp
// Datapath: previous-ring state, stitch counters with cross-product
// accumulators, vertex index adders and the output register.
// ----------------------------------------------------------------------------
module rpts_dp #(
  parameter int MAX_SEGMENTS = rpts_pkg::MAX_SEGMENTS_DEF,
  parameter int INDEX_BITS   = rpts_pkg::INDEX_BITS_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire  [rpts_pkg::SEG_W-1:0]   ring_segments,
  input  wire                          first_ring,
  input  rpts_pkg::rpts_cmd_t          cmd,
  output rpts_pkg::rpts_sts_t          sts,
  output logic [rpts_pkg::VTX_W-1:0]   vertex_a,
  output logic [rpts_pkg::VTX_W-1:0]   vertex_b,
  output logic [rpts_pkg::VTX_W-1:0]   vertex_c,
  output logic                         last_triangle,
  output logic                         index_overflow
);
  import rpts_pkg::*;

  localparam int NSEG_W = $clog2(MAX_SEGMENTS + 1);
  localparam int CNT_W  = $clog2(2 * MAX_SEGMENTS + 1);
  localparam int ACC_W  = CNT_W + NSEG_W;
  localparam int SUM_W  = INDEX_BITS + 1;
  localparam int EXT_W  = (INDEX_BITS > VTX_W) ? INDEX_BITS : VTX_W;

  // ring-local index wrap: v mod (n+1), v never beyond n+1 unless n is zero
  function automatic logic [NSEG_W-1:0] wrap_idx(input logic [CNT_W:0] v,
                                                 input logic [NSEG_W-1:0] n);
    logic [NSEG_W-1:0] r;
    if (n == '0) begin
      r = '0;
    end else if (v > (CNT_W + 1)'(n)) begin
      r = '0;
    end else begin
      r = v[NSEG_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [VTX_W-1:0] to_vtx(input logic [INDEX_BITS-1:0] idx);
    logic [EXT_W-1:0] ext;
    ext = EXT_W'(idx);
    return ext[VTX_W-1:0];
  endfunction

  // previous ring
  logic [NSEG_W-1:0]     prev_seg_r;
  logic [INDEX_BITS-1:0] prev_base_r;
  logic                  sticky_r;
  logic                  have_r;

  // current pair
  logic [NSEG_W-1:0]     num_a_r, num_b_r;
  logic [INDEX_BITS-1:0] base_a_r, base_b_r;
  logic                  run_sticky_r;
  logic [CNT_W-1:0]      idx_a_r, idx_b_r, rem_r;
  logic [ACC_W-1:0]      acc_a_r, acc_b_r;

  // output word
  logic [VTX_W-1:0]      vtx_a_r, vtx_b_r, vtx_c_r;
  logic                  last_r, ovf_r;

  logic [NSEG_W-1:0]     seg_sat;
  logic [CNT_W-1:0]      total;
  logic [SUM_W-1:0]      raw_b;
  logic                  a_side;
  logic [NSEG_W-1:0]     oa0, oa1, ob0, ob1;
  logic [INDEX_BITS-1:0] base0, base1, base2;
  logic [NSEG_W-1:0]     off0, off1, off2;
  logic [SUM_W-1:0]      sum0, sum1, sum2;

  assign seg_sat = (ring_segments > SEG_W'(MAX_SEGMENTS)) ? NSEG_W'(MAX_SEGMENTS)
                                                          : NSEG_W'(ring_segments);
  assign total   = CNT_W'(prev_seg_r) + CNT_W'(seg_sat);
  assign raw_b   = {1'b0, prev_base_r} + SUM_W'(prev_seg_r) + SUM_W'(1);

  assign sts.new_mesh   = first_ring || !have_r;
  assign sts.pair_empty = (total == '0);
  assign sts.last_step  = (rem_r == CNT_W'(1));

  // A-side triangle when idxA*numB <= idxB*numA
  assign a_side = (acc_a_r <= acc_b_r);

  assign oa0 = wrap_idx({1'b0, idx_a_r}, num_a_r);
  assign oa1 = wrap_idx({1'b0, idx_a_r} + (CNT_W + 1)'(1), num_a_r);
  assign ob0 = wrap_idx({1'b0, idx_b_r}, num_b_r);
  assign ob1 = wrap_idx({1'b0, idx_b_r} + (CNT_W + 1)'(1), num_b_r);

  always_comb begin
    if (a_side) begin
      base0 = base_a_r; off0 = oa0;
      base1 = base_a_r; off1 = oa1;
      base2 = base_b_r; off2 = ob0;
    end else begin
      base0 = base_b_r; off0 = ob1;
      base1 = base_b_r; off1 = ob0;
      base2 = base_a_r; off2 = oa0;
    end
  end

  assign sum0 = {1'b0, base0} + SUM_W'(off0);
  assign sum1 = {1'b0, base1} + SUM_W'(off1);
  assign sum2 = {1'b0, base2} + SUM_W'(off2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_seg_r  <= '0;
      prev_base_r <= '0;
      sticky_r    <= 1'b0;
      have_r      <= 1'b0;
    end else if (cmd.load_first) begin
      prev_seg_r  <= seg_sat;
      prev_base_r <= '0;
      sticky_r    <= 1'b0;
      have_r      <= 1'b1;
    end else if (cmd.start) begin
      prev_seg_r  <= seg_sat;
      prev_base_r <= raw_b[INDEX_BITS-1:0];
      sticky_r    <= sticky_r || raw_b[INDEX_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      num_a_r      <= prev_seg_r;
      num_b_r      <= seg_sat;
      base_a_r     <= prev_base_r;
      base_b_r     <= raw_b[INDEX_BITS-1:0];
      run_sticky_r <= sticky_r || raw_b[INDEX_BITS];
      idx_a_r      <= '0;
      idx_b_r      <= '0;
      acc_a_r      <= '0;
      acc_b_r      <= '0;
      rem_r        <= total;
    end else if (cmd.emit) begin
      rem_r <= rem_r - CNT_W'(1);
      if (a_side) begin
        idx_a_r <= idx_a_r + CNT_W'(1);
        acc_a_r <= acc_a_r + ACC_W'(num_b_r);
      end else begin
        idx_b_r <= idx_b_r + CNT_W'(1);
        acc_b_r <= acc_b_r + ACC_W'(num_a_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      vtx_a_r <= to_vtx(sum0[INDEX_BITS-1:0]);
      vtx_b_r <= to_vtx(sum1[INDEX_BITS-1:0]);
      vtx_c_r <= to_vtx(sum2[INDEX_BITS-1:0]);
      last_r  <= sts.last_step;
      ovf_r   <= run_sticky_r || sum0[INDEX_BITS] || sum1[INDEX_BITS] || sum2[INDEX_BITS];
    end
  end

  assign vertex_a       = vtx_a_r;
  assign vertex_b       = vtx_b_r;
  assign vertex_c       = vtx_c_r;
  assign last_triangle  = last_r;
  assign index_overflow = ovf_r;

endmodule
`default_nettype wire

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ring pair triangle stitcher.
// ----------------------------------------------------------------------------
// Rings go in as single words. The expected triangles of each accepted ring
// are computed by a behavioral stitcher kept in step with the block. Every
// triangle that comes out is compared field by field with the oldest
// expected one. Covered: directed corner rings, random meshes with broken
// sequences mixed in, and one mesh of wide rings run with no idling.
// Both handshakes are throttled at random, except in that one long stretch.
// ----------------------------------------------------------------------------
module tb_top;
  import rpts_pkg::*;

  localparam int MAX_SEG        = MAX_SEGMENTS_DEF;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int RANDOM_RINGS   = 125;

  typedef struct packed {
    logic [VTX_W-1:0] vtx_a;
    logic [VTX_W-1:0] vtx_b;
    logic [VTX_W-1:0] vtx_c;
    logic             last;
    logic             ovf;
  } triangle_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;   // [5:0] ring_segments, [7:6] zero
  logic                  in_tuser;   // first_ring
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;  // [15:0] vertex_a, [31:16] vertex_b, [47:32] vertex_c
  logic                  out_tlast;  // last_triangle
  logic                  out_tuser;  // index_overflow

  // behavioral stitcher state
  int unsigned   prev_segments;
  logic [16:0]   prev_base;      // bit 16: sticky wrap flag
  bit            mesh_open;
  triangle_t     expected_triangles[$];

  bit            no_idle;
  int unsigned   error_count;
  int unsigned   rings_sent;
  int unsigned   meshes_started;
  int unsigned   base_wraps;
  int unsigned   triangles_checked;
  int unsigned   quiet_cycles;
  triangle_t     oldest;

  ring_pair_triangle_stitcher u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always #1 clk = ~clk;

  always @(negedge clk) begin
    out_tready <= no_idle || ($urandom_range(99) >= 15);
  end

  task automatic note_error(input string msg);
    error_count++;
    if (error_count <= 10) begin
      $display("ERROR: %s", msg);
    end
  endtask

  task automatic check_field(input string name, input int unsigned want_v,
                             input int unsigned got_v);
    if (want_v != got_v) begin
      note_error($sformatf("triangle %0d %s: expected %0d, got %0d",
                           triangles_checked, name, want_v, got_v));
    end
  endtask

  // Works out the triangles one accepted ring yields and queues them.
  task automatic stitch_ring(input logic [5:0] seg_field, input logic first_flag);
    int unsigned seg, num_a, num_b, base_a, ia, ib, total;
    logic [16:0] raw_b, va, vb, vc;
    bit          sticky;
    triangle_t   want;
    seg = (seg_field > MAX_SEG) ? MAX_SEG : seg_field;
    rings_sent++;
    if (first_flag || !mesh_open) begin
      mesh_open     = 1'b1;
      prev_segments = seg;
      prev_base     = '0;
      meshes_started++;
      return;
    end
    num_a  = prev_segments;
    num_b  = seg;
    base_a = prev_base[15:0];
    sticky = prev_base[16];
    raw_b  = 17'(base_a + num_a + 1);
    if (raw_b[16] && !sticky) begin
      base_wraps++;
    end
    sticky = sticky | raw_b[16];
    ia     = 0;
    ib     = 0;
    total  = num_a + num_b;
    for (int j = 0; j < total; j++) begin
      if (ia * num_b <= ib * num_a) begin
        // A-based: two on the older ring, one on the newer
        va = 17'(base_a + ia % (num_a + 1));
        vb = 17'(base_a + (ia + 1) % (num_a + 1));
        vc = 17'(raw_b[15:0] + ib % (num_b + 1));
        ia++;
      end else begin
        va = 17'(raw_b[15:0] + (ib + 1) % (num_b + 1));
        vb = 17'(raw_b[15:0] + ib % (num_b + 1));
        vc = 17'(base_a + ia % (num_a + 1));
        ib++;
      end
      want.vtx_a = va[15:0];
      want.vtx_b = vb[15:0];
      want.vtx_c = vc[15:0];
      want.last  = (j + 1 == total);
      want.ovf   = sticky | va[16] | vb[16] | vc[16];
      expected_triangles.push_back(want);
    end
    prev_segments = seg;
    prev_base     = {sticky, raw_b[15:0]};
  endtask

  // Entered and left at a falling edge; valid stays up for a following word.
  task automatic send_ring(input logic [5:0] seg, input logic first_flag);
    while (!no_idle && $urandom_range(99) < 15) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = {2'b00, seg};
    in_tuser  = first_flag;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    stitch_ring(seg, first_flag);
    @(negedge clk);
  endtask

  function automatic logic [5:0] pick_segments();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 5) begin
      return 6'd0;
    end else if (r < 12) begin
      return 6'($urandom_range(63, 33));
    end else if (r < 35) begin
      return 6'($urandom_range(4, 1));
    end
    return 6'($urandom_range(32, 1));
  endfunction

  // Right after reset: a ring with no first flag still opens the mesh.
  task automatic test_orphan_ring();
    send_ring(6'd5, 1'b0);
    send_ring(6'd3, 1'b0);
  endtask

  task automatic test_directed_pairs();
    send_ring(6'd4, 1'b1);
    send_ring(6'd4, 1'b0);
    send_ring(6'd7, 1'b0);
    send_ring(6'd1, 1'b0);
    send_ring(6'd32, 1'b0);
    send_ring(6'd32, 1'b0);
    send_ring(6'd1, 1'b0);
    send_ring(6'd2, 1'b0);
  endtask

  // Zero rings, saturated counts, and a new mesh in the middle of one.
  task automatic test_special_cases();
    send_ring(6'd0, 1'b1);
    send_ring(6'd0, 1'b0);
    send_ring(6'd5, 1'b0);
    send_ring(6'd0, 1'b0);
    send_ring(6'd33, 1'b0);
    send_ring(6'd63, 1'b0);
    send_ring(6'd40, 1'b0);
    send_ring(6'd6, 1'b1);
    send_ring(6'd1, 1'b0);
  endtask

  task automatic test_random_meshes();
    int unsigned sent, mesh_len;
    sent = 0;
    while (sent < RANDOM_RINGS) begin
      mesh_len = $urandom_range(10, 2);
      for (int k = 0; k < mesh_len; k++) begin
        // an occasional stray first flag breaks the mesh
        send_ring(pick_segments(), (k == 0) || ($urandom_range(99) < 4));
        sent++;
      end
    end
  endtask

  // A mesh of wide rings with neither side idling, then a short new mesh.
  task automatic test_full_rate();
    no_idle = 1'b1;
    send_ring(6'd32, 1'b1);
    for (int k = 0; k < 12; k++) begin
      send_ring(6'($urandom_range(32, 24)), 1'b0);
    end
    no_idle = 1'b0;
    send_ring(6'd9, 1'b1);
    send_ring(6'd12, 1'b0);
    send_ring(6'd3, 1'b0);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_triangles.size() == 0) begin
        note_error($sformatf("unexpected triangle %0h last=%0b ovf=%0b",
                             out_tdata, out_tlast, out_tuser));
      end else begin
        oldest = expected_triangles.pop_front();
        check_field("vertex_a", oldest.vtx_a, out_tdata[15:0]);
        check_field("vertex_b", oldest.vtx_b, out_tdata[31:16]);
        check_field("vertex_c", oldest.vtx_c, out_tdata[47:32]);
        check_field("last_triangle", oldest.last, out_tlast);
        check_field("index_overflow", oldest.ovf, out_tuser);
      end
      triangles_checked++;
    end
  end

  // watchdog: no word moving on either side for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d quiet cycles", quiet_cycles);
      $display("ring_pair_triangle_stitcher regression: fail");
      $finish;
    end
  end

  initial begin
    rst_n             = 1'b0;
    in_tvalid         = 1'b0;
    in_tdata          = '0;
    in_tuser          = 1'b0;
    out_tready        = 1'b0;
    no_idle           = 1'b0;
    mesh_open         = 1'b0;
    prev_segments     = 0;
    prev_base         = '0;
    error_count       = 0;
    rings_sent        = 0;
    meshes_started    = 0;
    base_wraps        = 0;
    triangles_checked = 0;
    quiet_cycles      = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_orphan_ring();
    test_directed_pairs();
    test_special_cases();
    test_random_meshes();
    test_full_rate();
    in_tvalid = 1'b0;

    while (expected_triangles.size() != 0) @(posedge clk);
    repeat (2 * MAX_SEG + 8) @(posedge clk);
    if (expected_triangles.size() != 0) begin
      note_error($sformatf("%0d triangles never arrived", expected_triangles.size()));
    end

    $display("covered %0d rings in %0d meshes, %0d triangles compared",
             rings_sent, meshes_started, triangles_checked);
    $display("base vertex wrapped in %0d mesh(es), %0d mismatches",
             base_wraps, error_count);
    if (error_count == 0) begin
      $display("ring_pair_triangle_stitcher regression: pass");
    end else begin
      $display("ring_pair_triangle_stitcher regression: fail");
    end
    $finish;
  end

endmodule
